/* hw/rtl/sipq_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted-insert priority queue package
// Sequencer states, result status codes, op codes and order selects shared by the queue unit.
// ---------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_HEAD   = 7'b0010000,
        S_POP    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic ORDER_LARGE_FIRST = 1'b0;
    localparam logic ORDER_SMALL_FIRST = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/sipq_ram.sv */
// ---------------------------------------------------------------------------
// Sorted-insert priority queue entry RAM
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/sorted_insert_priority_queue_unit.sv */
// Insert scans for its position, moves the entries from there one place toward the tail
// and writes the new entry; no entry moves at the tail or in an empty queue.
// Remove reads the head, moving later entries up; full or empty ops go to the result.
// One word in flight: the next word is taken no sooner than its result can be.
// Reset clears the entry count, order select and output valid; RAM contents are kept.
// ---------------------------------------------------------------------------
// Sorted-insert priority queue unit
// Sorted list of key/payload entries in a RAM, insert and remove driven by a
// small sequencer around one shared key comparator.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 16,
    localparam int CW  = $clog2(QUEUE_DEPTH + 1),
    localparam int S_W = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8,
    localparam int M_W = ((KEY_WIDTH + PAYLOAD_WIDTH + CW + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,    // order_select
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_W-1:0]        s_tdata,      // item_key, item_payload
    input  wire logic                  s_tuser,      // op
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_W-1:0]        m_tdata,      // out_key, out_payload, fill_count
    output sipq_pkg::status_t          m_tuser       // status
);

    import sipq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    state_t                   state_reg, state_next;
    logic                     op_reg, op_next;
    logic [KEY_WIDTH-1:0]     key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [AW-1:0]            pos_reg, pos_next;
    status_t                  status_reg, status_next;
    logic [KEY_WIDTH-1:0]     rkey_reg, rkey_next;
    logic [PAYLOAD_WIDTH-1:0] rpay_reg, rpay_next;
    logic                     order_reg;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]           m_tdata_reg, m_tdata_next;
    status_t                  m_tuser_reg, m_tuser_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [EW-1:0]            ram_rdata;

    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic                     ranks_below;
    logic [CW-1:0]            count_m1;
    logic [AW-1:0]            idx_last;
    logic [CW-1:0]            idx_ext_inc;
    logic [AW-1:0]            idx_inc;
    logic                     out_free;
    logic [CW-1:0]            count_new;

    sipq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key      = ram_rdata[KEY_WIDTH-1:0];
    assign rd_pay      = ram_rdata[EW-1:KEY_WIDTH];
    assign ranks_below = (order_reg == ORDER_LARGE_FIRST) ? (rd_key < key_reg)
                                                          : (rd_key > key_reg);
    assign count_m1    = count_reg - CW'(1);
    assign idx_last    = count_m1[AW-1:0];
    assign idx_ext_inc = CW'(idx_reg) + CW'(1);
    assign idx_inc     = idx_reg + AW'(1);
    assign out_free    = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (status_reg != ST_OK)
        begin
            count_new = count_reg;
        end
        else if (op_reg == OP_INSERT)
        begin
            count_new = count_reg + CW'(1);
        end
        else
        begin
            count_new = count_m1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        rkey_next     = rkey_reg;
        rpay_next     = rpay_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    key_next    = s_tdata[KEY_WIDTH-1:0];
                    pay_next    = s_tdata[EW-1:KEY_WIDTH];
                    status_next = ST_OK;
                    rkey_next   = '0;
                    rpay_next   = '0;
                    idx_next    = '0;
                    pos_next    = '0;
                    if (s_tuser == OP_INSERT)
                    begin
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESULT;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_HEAD;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (ranks_below)
                begin
                    pos_next   = idx_reg;
                    idx_next   = idx_last;
                    ram_raddr  = idx_last;
                    state_next = S_SHIFT;
                end
                else if (idx_ext_inc == count_reg)
                begin
                    pos_next   = count_reg[AW-1:0];
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc;
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_inc;
                ram_wdata = ram_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next  = idx_reg - AW'(1);
                    ram_raddr = idx_reg - AW'(1);
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = {pay_reg, key_reg};
                state_next = S_RESULT;
            end
            S_HEAD:
            begin
                rkey_next = rd_key;
                rpay_next = rd_pay;
                if (count_reg == CW'(1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next   = AW'(1);
                    ram_raddr  = AW'(1);
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (idx_reg == idx_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    count_next    = count_new;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_W'({count_new, rpay_reg, rkey_reg});
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            order_reg    <= ORDER_LARGE_FIRST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                order_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        rkey_reg    <= rkey_next;
        rpay_reg    <= rpay_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_no_write_outside_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESULT) |-> !ram_we)
        else $error("entry RAM written outside insert or remove work");

    a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_reg >= pos_reg))
        else $error("shift index passed insert position");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && status_reg == ST_FULL) |-> (count_reg == CW'(QUEUE_DEPTH)))
        else $error("full status with free entries");

    a_fill_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_free) |=>
            (m_tvalid_reg && m_tdata_reg[EW+CW-1:EW] == count_reg))
        else $error("reported fill count differs from held entries");

endmodule

`default_nettype wire
